### hw/rtl/i2cmts_pkg.sv
// i2cmts_pkg: shared types and codes for the i2c master transfer sequencer
// no dependencies; imported by the sequencer core
package i2cmts_pkg;

	// request codes on the input channel
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_EVENT = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// bus actions returned with each result
	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_START    = 3'd1,
		ACT_TX       = 3'd2,
		ACT_STOP     = 3'd3,
		ACT_RX_ACK   = 3'd4,
		ACT_RX_NACK  = 3'd5,
		ACT_RESTART  = 3'd6,
		ACT_RESET_IF = 3'd7
	} action_t;

	// bus status event codes
	localparam logic [3:0] EV_START      = 4'd0;
	localparam logic [3:0] EV_REP_START  = 4'd1;
	localparam logic [3:0] EV_ADRW_ACK   = 4'd2;
	localparam logic [3:0] EV_DATAW_ACK  = 4'd3;
	localparam logic [3:0] EV_DATAR_ACK  = 4'd4;
	localparam logic [3:0] EV_ADRR_ACK   = 4'd5;
	localparam logic [3:0] EV_DATAR_NACK = 4'd6;
	localparam logic [3:0] EV_ARB_LOST   = 4'd7;

	// status byte mask, clears the two low bits; the core ORs them back, so all bits are kept
	localparam logic [7:0] STATUS_MASK = 8'hFC;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] device_address;
		logic       read_write;
		logic [3:0] message_size;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [3:0] bus_event;
		logic [7:0] raw_status;
		logic [7:0] received_byte;
	} in_item_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] tx_byte;
		logic       busy_res;
		logic       done_ok;
		logic       error_seen;
		logic [7:0] error_status;
		logic [7:0] read_byte;
	} out_item_t;

endpackage

### hw/rtl/i2cmts_ram.sv
// i2cmts_ram: generic memory, one write port and two registered read ports
// no dependencies; used for the frame buffer of the sequencer core
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### hw/rtl/i2c_master_transfer_sequencer_core.sv
// i2c_master_transfer_sequencer_core: top level of the i2c transfer sequencer
// depends on i2cmts_pkg and i2cmts_ram
//
//  channel   | signals                      | moves
//  ----------+------------------------------+-------------------------------
//  in        | in_valid, in_ready, in_data  | one request transaction
//  out       | out_valid, out_ready, out_data | one result transaction
//
// one result per request; a request passes stage one (decode and frame buffer read), then
// the output register; one request per cycle sustained while out_ready is high
// the frame buffer read port and the state update sit in the same first stage
// arst_n clears the transfer state and both valid flags; the buffer is not cleared
// with out_ready low requests are taken until both registers are full, then in_ready drops
module i2c_master_transfer_sequencer_core
	import i2cmts_pkg::*;
#(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW   = $clog2(BUFFER_DEPTH);
	localparam int PW   = $clog2(BUFFER_DEPTH + 1);
	localparam int CMPW = ((PW > 5) ? PW : 5) + 1;
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(BUFFER_DEPTH);

	// transfer state
	logic [PW-1:0] bp_q, bp_d;
	logic [PW-1:0] len_q, len_d;
	logic          done_q, done_d;
	logic          err_q, err_d;
	logic [7:0]    status_q, status_d;
	logic          busy_q, busy_d;

	// stage one and output register
	logic      valid_s1;
	action_t   action_s1;
	logic      busy_s1, done_s1, err_s1, tx_sel_s1, rd_sel_s1;
	logic [7:0] status_s1;
	logic      valid_s2;
	out_item_t out_s2;

	// decode results
	action_t       act;
	logic          tx_sel, rd_sel;
	logic          we;
	logic [IW-1:0] waddr, raddr_tx;
	logic [7:0]    wdata;
	logic [7:0]    rdata_rd, rdata_tx;

	logic [CMPW-1:0] slot, ptr, bp_ext, bp_inc, len_ext, size_len;
	logic            accept, adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// next state and bus action for the request
	always_comb begin
		slot     = CMPW'(in_data.byte_index) + CMPW'(1);
		bp_ext   = CMPW'(bp_q);
		len_ext  = CMPW'(len_q);
		size_len = CMPW'(in_data.message_size) + CMPW'(1);
		ptr      = (in_data.bus_event == EV_START || in_data.bus_event == EV_REP_START)
			? '0 : bp_ext;
		bp_inc   = bp_ext + CMPW'(1);
		bp_d     = bp_q;
		len_d    = len_q;
		done_d   = done_q;
		err_d    = err_q;
		status_d = status_q;
		busy_d   = busy_q;
		act      = ACT_NONE;
		tx_sel   = 1'b0;
		rd_sel   = 1'b0;
		we       = 1'b0;
		waddr    = slot[IW-1:0];
		wdata    = in_data.byte_value;
		raddr_tx = ptr[IW-1:0];
		case (req_t'(in_data.req_type))
			REQ_LOAD: begin
				we = !busy_q && (slot < DEPTH_C);
			end
			REQ_START: begin
				if (!busy_q) begin
					we       = 1'b1;
					waddr    = '0;
					wdata    = {in_data.device_address, in_data.read_write};
					len_d    = (size_len > DEPTH_C) ? PW'(BUFFER_DEPTH) : PW'(size_len);
					done_d   = 1'b0;
					err_d    = 1'b0;
					status_d = '0;
					busy_d   = 1'b1;
					act      = ACT_START;
				end
			end
			REQ_EVENT: begin
				if (busy_q) begin
					waddr = bp_q[IW-1:0];
					wdata = in_data.received_byte;
					case (in_data.bus_event)
						EV_START, EV_REP_START, EV_ADRW_ACK, EV_DATAW_ACK: begin
							if (ptr < len_ext && ptr < DEPTH_C) begin
								bp_d   = PW'(ptr + CMPW'(1));
								tx_sel = 1'b1;
								act    = ACT_TX;
							end else begin
								bp_d   = PW'(ptr);
								done_d = 1'b1;
								busy_d = 1'b0;
								act    = ACT_STOP;
							end
						end
						EV_DATAR_ACK: begin
							if (bp_ext < DEPTH_C) begin
								we   = 1'b1;
								bp_d = PW'(bp_inc);
								act  = (bp_inc + CMPW'(1) < len_ext) ? ACT_RX_ACK : ACT_RX_NACK;
							end else begin
								act  = (bp_inc < len_ext) ? ACT_RX_ACK : ACT_RX_NACK;
							end
						end
						EV_ADRR_ACK: begin
							act = (bp_inc < len_ext) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						EV_DATAR_NACK: begin
							we     = bp_ext < DEPTH_C;
							done_d = 1'b1;
							busy_d = 1'b0;
							act    = ACT_STOP;
						end
						EV_ARB_LOST: begin
							act = ACT_RESTART;
						end
						default: begin
							// nacks, bus error and unknown codes end the transfer
							status_d = in_data.raw_status & (STATUS_MASK | 8'h03);
							err_d    = 1'b1;
							busy_d   = 1'b0;
							act      = ACT_RESET_IF;
						end
					endcase
				end
			end
			REQ_READ: begin
				rd_sel = done_q && (slot < DEPTH_C);
			end
			default: begin
				act = ACT_NONE;
			end
		endcase
	end

	// frame buffer
	i2cmts_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_frame_buf (
		.clk     (clk),
		.we      (accept && we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr_a (slot[IW-1:0]),
		.raddr_b (raddr_tx),
		.rdata_a (rdata_rd),
		.rdata_b (rdata_tx)
	);

	// transfer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q     <= '0;
			len_q    <= '0;
			done_q   <= 1'b0;
			err_q    <= 1'b0;
			status_q <= '0;
			busy_q   <= 1'b0;
		end else if (accept) begin
			bp_q     <= bp_d;
			len_q    <= len_d;
			done_q   <= done_d;
			err_q    <= err_d;
			status_q <= status_d;
			busy_q   <= busy_d;
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= act;
			busy_s1   <= busy_d;
			done_s1   <= done_d;
			err_s1    <= err_d;
			status_s1 <= status_d;
			tx_sel_s1 <= tx_sel;
			rd_sel_s1 <= rd_sel;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2.action       <= action_s1;
			out_s2.tx_byte      <= tx_sel_s1 ? rdata_tx : 8'h00;
			out_s2.busy_res     <= busy_s1;
			out_s2.done_ok      <= done_s1;
			out_s2.error_seen   <= err_s1;
			out_s2.error_status <= status_s1;
			out_s2.read_byte    <= rd_sel_s1 ? rdata_rd : 8'h00;
		end
	end

	// a transfer cannot end both well and in error
	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && err_q))
		else $error("done and error flags both set");

	// an active transfer always has at least the address byte
	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (len_q != '0))
		else $error("busy with empty frame");

	// a start leaves the transfer busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && action_s1 == ACT_START) |-> busy_s1)
		else $error("start issued without busy");

	// tx byte is zero unless a byte is being transmitted
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_s2.action != ACT_TX) |-> (out_s2.tx_byte == 8'h00))
		else $error("tx byte set without transmit action");

	// with no result waiting the input side is open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty output");

endmodule
